[sv/lbc_pkg.sv]
package lbc_pkg;

  // Number of cache slots and the width of a slot index.
  localparam int unsigned SLOTS = 16;
  localparam int unsigned SlotW = $clog2(SLOTS);

  // Field widths of the transactions.
  localparam int unsigned FileW      = 16;
  localparam int unsigned BlockW     = 20;
  localparam int unsigned StampW     = 32;
  localparam int unsigned SlotFieldW = 4;

  // Function codes of an input transaction.
  localparam logic FuncLookup = 1'b0;
  localparam logic FuncInval  = 1'b1;

  // Kinds of write-back that the controller broadcasts to the slot cells.
  typedef enum logic [1:0] {
    WR_STAMP,
    WR_FILL,
    WR_CLEAR
  } wr_kind_e;

  // Lookup record that walks along the chain of cells.
  typedef struct packed {
    logic              valid;
    logic [FileW-1:0]  fid;
    logic [BlockW-1:0] blk;
    logic              found;
    logic [SlotW-1:0]  idx;
    logic [SlotW-1:0]  vidx;
    logic [StampW-1:0] vstamp;
  } rec_t;

  // Write-back command, seen by every cell at once.
  typedef struct packed {
    logic              we;
    wr_kind_e          kind;
    logic [SlotW-1:0]  idx;
    logic [FileW-1:0]  fid;
    logic [BlockW-1:0] blk;
    logic [StampW-1:0] stamp;
  } wr_t;

endpackage

[sv/lbc_cell.sv]
module lbc_cell (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic [lbc_pkg::SlotW-1:0] idx_i,
  input  lbc_pkg::rec_t            rec_i,
  output lbc_pkg::rec_t            rec_o,
  input  lbc_pkg::wr_t             wr_i
);
  import lbc_pkg::*;

  logic [FileW-1:0]  file_q;
  logic [BlockW-1:0] block_q;
  logic [StampW-1:0] stamp_q;
  rec_t              rec_d;
  logic              valid_q;
  rec_t              pay_q;
  logic              match;

  assign match = (file_q == rec_i.fid) && (block_q == rec_i.blk);

  // A record that already found its slot passes unchanged; otherwise this
  // slot either matches or may become the oldest one seen so far.
  always_comb begin
    rec_d = rec_i;
    if (!rec_i.found) begin
      if (match) begin
        rec_d.found = 1'b1;
        rec_d.idx   = idx_i;
      end else if (stamp_q < rec_i.vstamp) begin
        rec_d.vidx   = idx_i;
        rec_d.vstamp = stamp_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= rec_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    pay_q <= rec_d;
  end

  always_comb begin
    rec_o       = pay_q;
    rec_o.valid = valid_q;
  end

  // Slot tag and stamp storage.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      file_q  <= '0;
      block_q <= '0;
      stamp_q <= '0;
    end else if (wr_i.we && (wr_i.idx == idx_i)) begin
      unique case (wr_i.kind)
        WR_STAMP: begin
          stamp_q <= wr_i.stamp;
        end
        WR_FILL: begin
          file_q  <= wr_i.fid;
          block_q <= wr_i.blk;
          stamp_q <= wr_i.stamp;
        end
        WR_CLEAR: begin
          file_q  <= '0;
          stamp_q <= '0;
        end
        default: begin
          stamp_q <= stamp_q;
        end
      endcase
    end
  end

endmodule

[sv/lru_block_cache_tag_lookup_core.sv]
// Tag and LRU replacement logic of a fully associative block cache with SLOTS
// slots (16 by default). A lookup transaction (func 0) presents a file id and a
// block number and travels down a chain of slot cells, one cell per cycle;
// each cell checks its tag and tracks the oldest stamp seen, lowest index on
// a tie. The result reports the hit slot, or on a miss the replaced slot with
// allocated set; either way the slot takes the next value of a 32-bit stamp
// counter that wraps. An invalidate transaction (func 1) clears the file id and
// stamp of target_slot, keeps its block number, and reports that slot with hit
// and allocated low. After a lookup is accepted, the next transaction waits
// for the walk through the cell chain and the write-back of the result; an
// invalidate goes straight to its write-back. A result that waits on
// out_stall_i holds the block at that point until the result register frees
// up. Only one transaction is in flight.
module lru_block_cache_tag_lookup_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          func_i,
  input  logic [lbc_pkg::FileW-1:0]      file_id_i,
  input  logic [lbc_pkg::BlockW-1:0]     block_index_i,
  input  logic [lbc_pkg::SlotFieldW-1:0] target_slot_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [lbc_pkg::SlotFieldW-1:0] slot_o,
  output logic                          hit_o,
  output logic                          allocated_o
);
  import lbc_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_HOLD
  } state_e;

  // Finished transaction waiting for write-back.
  typedef struct packed {
    logic                  inval;
    logic [SlotFieldW-1:0] tgt;
    rec_t                  rec;
  } fin_t;

  state_e                state_q;
  fin_t                  hold_q;
  fin_t                  fin;
  logic [StampW-1:0]     counter_q;
  logic [StampW-1:0]     stamp_next;
  logic                  out_valid_q;
  logic [SlotFieldW-1:0] slot_q;
  logic                  hit_q;
  logic                  alloc_q;
  logic                  accept;
  logic                  out_free;
  logic                  commit;
  logic                  tgt_ok;
  wr_t                   wr;
  rec_t                  chain [SLOTS+1];

  assign in_stall_o = (state_q != ST_IDLE);
  assign accept     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;

  // A lookup enters the first cell on the edge that accepts it. The oldest
  // stamp starts at all ones so that slot zero is the default victim.
  always_comb begin
    chain[0].valid  = accept && (func_i == FuncLookup);
    chain[0].fid    = file_id_i;
    chain[0].blk    = block_index_i;
    chain[0].found  = 1'b0;
    chain[0].idx    = '0;
    chain[0].vidx   = '0;
    chain[0].vstamp = '1;
  end

  for (genvar i = 0; i < SLOTS; i++) begin : g_cell
    lbc_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .idx_i  (SlotW'(i)),
      .rec_i  (chain[i]),
      .rec_o  (chain[i+1]),
      .wr_i   (wr)
    );
  end

  // The record leaving the last cell is committed directly when the result
  // register is free; otherwise it is parked in the hold register.
  always_comb begin
    if (state_q == ST_SCAN) begin
      fin.inval = 1'b0;
      fin.tgt   = '0;
      fin.rec   = chain[SLOTS];
    end else begin
      fin = hold_q;
    end
  end

  assign commit = out_free &&
                  (((state_q == ST_SCAN) && chain[SLOTS].valid) || (state_q == ST_HOLD));
  assign tgt_ok     = (32'(fin.tgt) < SLOTS);
  assign stamp_next = counter_q + StampW'(1);

  always_comb begin
    wr.we    = commit && (!fin.inval || tgt_ok);
    wr.fid   = fin.rec.fid;
    wr.blk   = fin.rec.blk;
    wr.stamp = stamp_next;
    if (fin.inval) begin
      wr.kind = WR_CLEAR;
      wr.idx  = SlotW'(fin.tgt);
    end else if (fin.rec.found) begin
      wr.kind = WR_STAMP;
      wr.idx  = fin.rec.idx;
    end else begin
      wr.kind = WR_FILL;
      wr.idx  = fin.rec.vidx;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      hold_q      <= '0;
      counter_q   <= '0;
      out_valid_q <= 1'b0;
      slot_q      <= '0;
      hit_q       <= 1'b0;
      alloc_q     <= 1'b0;
    end else begin
      if (commit) begin
        out_valid_q <= 1'b1;
        hit_q       <= !fin.inval && fin.rec.found;
        alloc_q     <= !fin.inval && !fin.rec.found;
        if (fin.inval) begin
          slot_q <= fin.tgt;
        end else if (fin.rec.found) begin
          slot_q <= SlotFieldW'(fin.rec.idx);
        end else begin
          slot_q <= SlotFieldW'(fin.rec.vidx);
        end
        if (!fin.inval) begin
          counter_q <= stamp_next;
        end
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        ST_IDLE: begin
          if (accept) begin
            if (func_i == FuncInval) begin
              hold_q.inval <= 1'b1;
              hold_q.tgt   <= target_slot_i;
              hold_q.rec   <= '0;
              state_q      <= ST_HOLD;
            end else begin
              state_q <= ST_SCAN;
            end
          end
        end
        ST_SCAN: begin
          if (chain[SLOTS].valid) begin
            if (commit) begin
              state_q <= ST_IDLE;
            end else begin
              hold_q  <= fin;
              state_q <= ST_HOLD;
            end
          end
        end
        ST_HOLD: begin
          if (commit) begin
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign slot_o      = slot_q;
  assign hit_o       = hit_q;
  assign allocated_o = alloc_q;

endmodule

[sv/lbc_chk.sv]
module lbc_chk (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_stall_o,
  input logic                          out_valid_o,
  input logic                          out_stall_i,
  input logic [lbc_pkg::SlotFieldW-1:0] slot_o,
  input logic                          hit_o,
  input logic                          allocated_o
);

  // A stalled result keeps its payload.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=>
      (out_valid_o && $stable(slot_o) && $stable(hit_o) && $stable(allocated_o)))
    else $error("stalled result changed");

  // Only one transaction is in flight: input stalls right after an accept.
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("input not stalled after accepting a transaction");

  // A result is never both a hit and an allocation.
  a_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(hit_o && allocated_o))
    else $error("hit and allocated both set");

  // A new result only appears while a transaction was being worked on.
  a_origin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result appeared without a transaction in flight");

endmodule

bind lru_block_cache_tag_lookup_core lbc_chk u_lbc_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .slot_o      (slot_o),
  .hit_o       (hit_o),
  .allocated_o (allocated_o)
);
